[rtl/ufv_pkg.sv]
// Shared types, constants and fixed-point helpers for the upwind face velocity block.
package ufv_pkg;

  // Field widths of the face stream and the configuration port.
  localparam int unsigned VelW  = 32;
  localparam int unsigned ThrW  = 31;
  localparam int unsigned PosW  = 2;
  localparam int unsigned KindW = 2;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned DataW = 32;

  // Width of a full product of two 33-bit signed operands.
  localparam int unsigned ProdW = 66;

  // One half in Q16.16.
  localparam logic signed [VelW-1:0] HalfQ16 = 32'sh0000_8000;

  // Configuration register indexes.
  typedef enum logic [IdxW-1:0] {
    CfgExtrapMode   = 3'd0,
    CfgCourantHalf  = 3'd1,
    CfgZeroThresh   = 3'd2,
    CfgBcLowKind    = 3'd3,
    CfgBcHighKind   = 3'd4,
    CfgBaseEnable   = 3'd5
  } cfg_idx_e;

  // Domain boundary kinds.
  typedef enum logic [KindW-1:0] {
    BcInflow   = 2'd0,
    BcWall     = 2'd1,
    BcOutflow  = 2'd2,
    BcInterior = 2'd3
  } bc_kind_e;

  // Face positions; the unused code is handled as an interior face.
  typedef enum logic [PosW-1:0] {
    FaceInterior = 2'd0,
    FaceLow      = 2'd1,
    FaceHigh     = 2'd2
  } face_pos_e;

  // Configuration state seen by the datapath.
  typedef struct packed {
    logic                extrap_mode;
    logic [VelW-1:0]     courant_half;
    logic [ThrW-1:0]     zero_threshold;
    bc_kind_e            bc_low_kind;
    bc_kind_e            bc_high_kind;
    logic                base_enable;
  } ufv_cfg_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [VelW-1:0] sat32(input logic signed [ProdW-1:0] x);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'(32'sh7FFF_FFFF);
    lo = ProdW'(32'sh8000_0000);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end else begin
      return x[VelW-1:0];
    end
  endfunction

  // Scale a Q16.16 product back with rounding toward minus infinity, then saturate.
  function automatic logic signed [VelW-1:0] qscale(input logic signed [ProdW-1:0] p);
    return sat32(p >>> 16);
  endfunction

endpackage

[rtl/ufv_if.sv]
// Valid/ready channel interfaces for faces, results and configuration writes.
interface ufv_in_if;
  import ufv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] cell_vel_left;
  logic signed [VelW-1:0] cell_vel_right;
  logic signed [VelW-1:0] full_vel_left;
  logic signed [VelW-1:0] full_vel_right;
  logic signed [VelW-1:0] aux_left;
  logic signed [VelW-1:0] aux_right;
  logic signed [VelW-1:0] base_vel;
  logic signed [VelW-1:0] ghost_vel;
  logic [PosW-1:0]        face_position;

  modport source (
    output valid, cell_vel_left, cell_vel_right, full_vel_left, full_vel_right,
           aux_left, aux_right, base_vel, ghost_vel, face_position,
    input  ready
  );
  modport sink (
    input  valid, cell_vel_left, cell_vel_right, full_vel_left, full_vel_right,
           aux_left, aux_right, base_vel, ghost_vel, face_position,
    output ready
  );
endinterface

interface ufv_out_if;
  import ufv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] trans_vel;

  modport source (output valid, trans_vel, input ready);
  modport sink (input valid, trans_vel, output ready);
endinterface

interface ufv_cfg_if;
  import ufv_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [DataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/ufv_riemann.sv]
// Upwind Riemann test on the face states, with optional base velocity.
module ufv_riemann (
  input  logic signed [ufv_pkg::VelW-1:0] l_i,
  input  logic signed [ufv_pkg::VelW-1:0] r_i,
  input  logic signed [ufv_pkg::VelW-1:0] base_i,
  input  ufv_pkg::ufv_cfg_t               cfg_i,
  output logic signed [ufv_pkg::VelW-1:0] res_o
);
  import ufv_pkg::*;

  localparam int unsigned SumW = VelW + 3;

  logic signed [VelW-1:0]   w;
  logic signed [VelW:0]     lw;
  logic signed [VelW:0]     rw;
  logic signed [SumW-1:0]   s;
  logic        [SumW-1:0]   s_abs;
  logic                     diverge;
  logic                     near_zero;

  // Sums of the states with the base velocity folded in.
  always_comb begin
    w         = cfg_i.base_enable ? base_i : '0;
    lw        = (VelW+1)'(l_i) + (VelW+1)'(w);
    rw        = (VelW+1)'(r_i) + (VelW+1)'(w);
    s         = SumW'(l_i) + SumW'(r_i) + (SumW'(w) <<< 1);
    s_abs     = s[SumW-1] ? SumW'(-s) : SumW'(s);
    diverge   = (lw <= 0) && (rw >= 0);
    near_zero = s_abs < SumW'(cfg_i.zero_threshold);
  end

  // Zero on a rarefaction or a vanishing sum, otherwise take the upwind side.
  always_comb begin
    if (diverge || near_zero) begin
      res_o = '0;
    end else if (s > 0) begin
      res_o = l_i;
    end else begin
      res_o = r_i;
    end
  end

endmodule

[rtl/upwind_face_velocity.sv]
// Top level: five-stage pipeline that upwinds the transverse velocity on one face per beat.
// A face accepted into stage 1 moves through stages 2, 3 and 4 into the stage 5 output register.
// Throughput: one face per cycle; stages hold under back-pressure and in_i.ready follows
// the ready of the first stage, which is high whenever that stage is empty or moving on.
// The stage split is set by the two multiply stages (Courant term, then slope term).
// Reset clears all stage valid bits and loads the register defaults (interior boundaries).
module upwind_face_velocity (
  input  logic  clk_i,
  input  logic  rst_ni,
  ufv_in_if.sink    in_i,
  ufv_out_if.source out_o,
  ufv_cfg_if.sink   cfg_i
);
  import ufv_pkg::*;

  // Configuration registers.
  ufv_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extrap_mode    <= 1'b0;
      cfg_q.courant_half   <= '0;
      cfg_q.zero_threshold <= '0;
      cfg_q.bc_low_kind    <= BcInterior;
      cfg_q.bc_high_kind   <= BcInterior;
      cfg_q.base_enable    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgExtrapMode:  cfg_q.extrap_mode    <= cfg_i.data[0];
        CfgCourantHalf: cfg_q.courant_half   <= cfg_i.data[VelW-1:0];
        CfgZeroThresh:  cfg_q.zero_threshold <= cfg_i.data[ThrW-1:0];
        CfgBcLowKind:   cfg_q.bc_low_kind    <= bc_kind_e'(cfg_i.data[KindW-1:0]);
        CfgBcHighKind:  cfg_q.bc_high_kind   <= bc_kind_e'(cfg_i.data[KindW-1:0]);
        CfgBaseEnable:  cfg_q.base_enable    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain from the output back to the input.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5       = !v5_q || out_o.ready;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 1: Courant products ch*max(0,fvl) and ch*min(0,fvr).
  logic signed [VelW-1:0]  fvl_pos, fvr_neg;
  logic signed [VelW:0]    ch_s;
  logic signed [VelW:0]    fvl_ext, fvr_ext;
  logic signed [ProdW-1:0] pcl_d, pcr_d;

  always_comb begin
    fvl_pos = (in_i.full_vel_left > 0) ? in_i.full_vel_left : '0;
    fvr_neg = (in_i.full_vel_right < 0) ? in_i.full_vel_right : '0;
    ch_s    = $signed({1'b0, cfg_q.courant_half});
    fvl_ext = (VelW+1)'(fvl_pos);
    fvr_ext = (VelW+1)'(fvr_neg);
    pcl_d   = ProdW'(ch_s) * ProdW'(fvl_ext);
    pcr_d   = ProdW'(ch_s) * ProdW'(fvr_ext);
  end

  logic signed [VelW-1:0]  s1_cvl_q, s1_cvr_q, s1_axl_q, s1_axr_q, s1_base_q, s1_ghost_q;
  logic [PosW-1:0]         s1_pos_q;
  logic signed [ProdW-1:0] s1_pcl_q, s1_pcr_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      s1_cvl_q   <= in_i.cell_vel_left;
      s1_cvr_q   <= in_i.cell_vel_right;
      s1_axl_q   <= in_i.aux_left;
      s1_axr_q   <= in_i.aux_right;
      s1_base_q  <= in_i.base_vel;
      s1_ghost_q <= in_i.ghost_vel;
      s1_pos_q   <= in_i.face_position;
      s1_pcl_q   <= pcl_d;
      s1_pcr_q   <= pcr_d;
    end
  end

  // Stage 2: slope coefficients 0.5 - ch*fvl and 0.5 + ch*fvr.
  logic signed [VelW-1:0] cl_d, cr_d;

  always_comb begin
    cl_d = sat32(ProdW'(HalfQ16) - ProdW'(qscale(s1_pcl_q)));
    cr_d = sat32(ProdW'(HalfQ16) + ProdW'(qscale(s1_pcr_q)));
  end

  logic signed [VelW-1:0] s2_cvl_q, s2_cvr_q, s2_axl_q, s2_axr_q, s2_base_q, s2_ghost_q;
  logic signed [VelW-1:0] s2_cl_q, s2_cr_q;
  logic [PosW-1:0]        s2_pos_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_cvl_q   <= s1_cvl_q;
      s2_cvr_q   <= s1_cvr_q;
      s2_axl_q   <= s1_axl_q;
      s2_axr_q   <= s1_axr_q;
      s2_base_q  <= s1_base_q;
      s2_ghost_q <= s1_ghost_q;
      s2_pos_q   <= s1_pos_q;
      s2_cl_q    <= cl_d;
      s2_cr_q    <= cr_d;
    end
  end

  // Stage 3: slope products cl*sl and cr*sr.
  logic signed [ProdW-1:0] psl_d, psr_d;

  always_comb begin
    psl_d = ProdW'(s2_cl_q) * ProdW'(s2_axl_q);
    psr_d = ProdW'(s2_cr_q) * ProdW'(s2_axr_q);
  end

  logic signed [VelW-1:0]  s3_cvl_q, s3_cvr_q, s3_axl_q, s3_axr_q, s3_base_q, s3_ghost_q;
  logic signed [ProdW-1:0] s3_psl_q, s3_psr_q;
  logic [PosW-1:0]         s3_pos_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_cvl_q   <= s2_cvl_q;
      s3_cvr_q   <= s2_cvr_q;
      s3_axl_q   <= s2_axl_q;
      s3_axr_q   <= s2_axr_q;
      s3_base_q  <= s2_base_q;
      s3_ghost_q <= s2_ghost_q;
      s3_pos_q   <= s2_pos_q;
      s3_psl_q   <= psl_d;
      s3_psr_q   <= psr_d;
    end
  end

  // Stage 4: extrapolated states, then the domain boundary rule.
  logic signed [VelW-1:0] ext_l, ext_r, l_d, r_d;
  bc_kind_e               kind;
  logic                   on_bound;

  always_comb begin
    if (cfg_q.extrap_mode) begin
      ext_l = s3_axl_q;
      ext_r = s3_axr_q;
    end else begin
      ext_l = sat32(ProdW'(s3_cvl_q) + ProdW'(qscale(s3_psl_q)));
      ext_r = sat32(ProdW'(s3_cvr_q) - ProdW'(qscale(s3_psr_q)));
    end

    case (face_pos_e'(s3_pos_q))
      FaceLow: begin
        on_bound = 1'b1;
        kind     = cfg_q.bc_low_kind;
      end
      FaceHigh: begin
        on_bound = 1'b1;
        kind     = cfg_q.bc_high_kind;
      end
      default: begin
        on_bound = 1'b0;
        kind     = BcInterior;
      end
    endcase

    l_d = ext_l;
    r_d = ext_r;
    if (on_bound) begin
      case (kind)
        BcInflow: begin
          l_d = s3_ghost_q;
          r_d = s3_ghost_q;
        end
        BcWall: begin
          l_d = '0;
          r_d = '0;
        end
        BcOutflow: begin
          if (face_pos_e'(s3_pos_q) == FaceLow) begin
            l_d = (ext_r < 0) ? ext_r : '0;
          end else begin
            l_d = (ext_l > 0) ? ext_l : '0;
          end
          r_d = l_d;
        end
        default: ;
      endcase
    end
  end

  logic signed [VelW-1:0] s4_l_q, s4_r_q, s4_base_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      s4_l_q    <= l_d;
      s4_r_q    <= r_d;
      s4_base_q <= s3_base_q;
    end
  end

  // Stage 5: Riemann solve into the output register.
  logic signed [VelW-1:0] res_d;
  logic signed [VelW-1:0] s5_res_q;

  ufv_riemann u_riemann (
    .l_i    (s4_l_q),
    .r_i    (s4_r_q),
    .base_i (s4_base_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      s5_res_q <= res_d;
    end
  end

  assign out_o.valid     = v5_q;
  assign out_o.trans_vel = s5_res_q;

  // A ready sink drains every stage, so the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input not ready while output side is ready");

  // A face held in stage 4 under back-pressure is still there next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !rdy5) |=> v4_q)
    else $error("stalled face dropped from stage 4");

  // The solved velocity is zero or one of the two face states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy5 && v4_q) |=> (s5_res_q == '0 || s5_res_q == $past(s4_l_q)
                        || s5_res_q == $past(s4_r_q)))
    else $error("result is neither zero nor an upwind state");

  // Stage 5 only fills from a valid stage 4 face.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v5_q && !v4_q) |=> !v5_q)
    else $error("output valid raised without a face in stage 4");

endmodule

[tb/sv/ufv_velocity_checker.sv]
// Checker that predicts the upwinded face velocity of each accepted face and scores the results.
module ufv_velocity_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ufv_in_if           face_i,
  ufv_out_if          vel_i,
  ufv_cfg_if          reg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import ufv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Local copy of the register file, tracked from the write channel.
  logic            cur_extrap;
  logic [VelW-1:0] cur_courant;
  logic [ThrW-1:0] cur_thresh;
  bc_kind_e        cur_low_kind;
  bc_kind_e        cur_high_kind;
  logic            cur_base_en;

  // Predicted velocities of faces still in flight, oldest first.
  logic [VelW-1:0] expected_vel_q[$];
  logic [VelW-1:0] want_vel;
  int unsigned     mismatches;
  int unsigned     results_seen;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Exact Q16.16 product, floored back to Q16.16 and clamped.
  function automatic longint fixmul(input longint a, input longint b);
    return clamp32((a * b) >>> 16);
  endfunction

  // Left and right states, boundary rule, then the upwind Riemann choice.
  function automatic logic [VelW-1:0] upwind_trans_vel(
    input logic signed [VelW-1:0] cvl, cvr, fvl, fvr, axl, axr, base, ghost,
    input logic [PosW-1:0] pos
  );
    longint   ch;
    longint   coef_l;
    longint   coef_r;
    longint   left;
    longint   right;
    longint   w;
    longint   sum;
    longint   mag;
    longint   res;
    bc_kind_e kind;
    ch = longint'({32'd0, cur_courant});
    if (cur_extrap == 1'b0) begin
      coef_l = clamp32(longint'(HalfQ16) - fixmul(ch, (fvl > 0) ? longint'(fvl) : 64'sd0));
      coef_r = clamp32(longint'(HalfQ16) + fixmul(ch, (fvr < 0) ? longint'(fvr) : 64'sd0));
      left   = clamp32(longint'(cvl) + fixmul(coef_l, longint'(axl)));
      right  = clamp32(longint'(cvr) - fixmul(coef_r, longint'(axr)));
    end else begin
      left  = longint'(axl);
      right = longint'(axr);
    end

    // Domain faces follow the boundary kind of their side; code 3 stays interior.
    if (pos == FaceLow || pos == FaceHigh) begin
      kind = (pos == FaceLow) ? cur_low_kind : cur_high_kind;
      case (kind)
        BcInflow: begin
          left  = longint'(ghost);
          right = left;
        end
        BcWall: begin
          left  = 64'sd0;
          right = 64'sd0;
        end
        BcOutflow: begin
          if (pos == FaceLow) begin
            left = (right < 0) ? right : 64'sd0;
          end else begin
            left = (left > 0) ? left : 64'sd0;
          end
          right = left;
        end
        default: begin
        end
      endcase
    end

    // Diverging states or a near-zero sum give zero; otherwise take the upwind side.
    w   = cur_base_en ? longint'(base) : 64'sd0;
    sum = left + right + 2 * w;
    mag = (sum < 0) ? -sum : sum;
    if ((left + w <= 0 && right + w >= 0) || mag < longint'({33'd0, cur_thresh})) begin
      res = 64'sd0;
    end else begin
      res = (sum > 0) ? left : right;
    end
    return res[VelW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_extrap    <= 1'b0;
      cur_courant   <= '0;
      cur_thresh    <= '0;
      cur_low_kind  <= BcInterior;
      cur_high_kind <= BcInterior;
      cur_base_en   <= 1'b0;
      expected_vel_q.delete();
      results_seen = 0;
      pending_o    = 0;
    end else begin
      // Predict each face beat as it is accepted.
      if (face_i.valid && face_i.ready) begin
        expected_vel_q.push_back(upwind_trans_vel(
          face_i.cell_vel_left, face_i.cell_vel_right, face_i.full_vel_left,
          face_i.full_vel_right, face_i.aux_left, face_i.aux_right,
          face_i.base_vel, face_i.ghost_vel, face_i.face_position));
      end

      // Score each result beat against the oldest prediction.
      if (vel_i.valid && vel_i.ready) begin
        results_seen++;
        if (expected_vel_q.size() == 0) begin
          report_mismatch($sformatf("result %0d (trans_vel %h) with no face pending",
                                    results_seen, vel_i.trans_vel));
        end else begin
          want_vel = expected_vel_q.pop_front();
          if (vel_i.trans_vel !== want_vel) begin
            report_mismatch($sformatf("result %0d trans_vel got %h expected %h",
                                      results_seen, vel_i.trans_vel, want_vel));
          end
        end
      end
      pending_o = expected_vel_q.size();

      // Follow register writes; indexes past the last register are dropped.
      if (reg_i.valid && reg_i.ready) begin
        case (reg_i.index)
          CfgExtrapMode:  cur_extrap    <= reg_i.data[0];
          CfgCourantHalf: cur_courant   <= reg_i.data[VelW-1:0];
          CfgZeroThresh:  cur_thresh    <= reg_i.data[ThrW-1:0];
          CfgBcLowKind:   cur_low_kind  <= bc_kind_e'(reg_i.data[KindW-1:0]);
          CfgBcHighKind:  cur_high_kind <= bc_kind_e'(reg_i.data[KindW-1:0]);
          CfgBaseEnable:  cur_base_en   <= reg_i.data[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[tb/sv/tb_upwind_face_velocity.sv]
// Testbench top: face and register stimulus, result back-pressure, and the final verdict.
module tb_upwind_face_velocity;
  import ufv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PhaseFaces = 150;
  localparam int unsigned IdlePct    = 27;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PipeDepth  = 5;
  localparam int unsigned CycleLimit = 400000;

  // Register indexes with no register behind them.
  localparam logic [IdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [IdxW-1:0] CfgSpareHi = 3'd7;
  // Face position code that has no name of its own.
  localparam logic [PosW-1:0] FaceSpare  = 2'd3;

  localparam logic [VelW-1:0] VelMax = 32'h7FFF_FFFF;
  localparam logic [VelW-1:0] VelMin = 32'h8000_0000;

  typedef struct packed {
    logic [VelW-1:0] cvl;
    logic [VelW-1:0] cvr;
    logic [VelW-1:0] fvl;
    logic [VelW-1:0] fvr;
    logic [VelW-1:0] axl;
    logic [VelW-1:0] axr;
    logic [VelW-1:0] base;
    logic [VelW-1:0] ghost;
    logic [PosW-1:0] pos;
  } face_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_req;

  ufv_in_if  face_if ();
  ufv_out_if vel_if ();
  ufv_cfg_if reg_if ();

  upwind_face_velocity uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (face_if),
    .out_o  (vel_if),
    .cfg_i  (reg_if)
  );

  ufv_velocity_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .face_i       (face_if),
    .vel_i        (vel_if),
    .reg_i        (reg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Give up if the run hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("upwind_face_velocity verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold while hold_req is up.
  initial begin : result_sink
    int unsigned held;
    held = 0;
    vel_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && held < HoldCycles) begin
        vel_if.ready <= 1'b0;
        held++;
      end else begin
        if (!hold_req) held = 0;
        vel_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Keeps valid high; the caller lowers it after the last write of a burst.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= data;
    do @(posedge clk_i); while (!reg_if.ready);
  endtask

  // Write every register, with junk above the width of each register narrower than the data.
  task automatic load_config(input logic mode, input logic [VelW-1:0] ch,
                             input logic [ThrW-1:0] thr, input bc_kind_e lo,
                             input bc_kind_e hi, input logic base_en);
    write_reg(CfgExtrapMode, {31'($urandom), mode});
    write_reg(CfgCourantHalf, ch);
    write_reg(CfgZeroThresh, {1'($urandom), thr});
    write_reg(CfgBcLowKind, {30'($urandom), lo});
    write_reg(CfgBcHighKind, {30'($urandom), hi});
    write_reg(CfgBaseEnable, {31'($urandom), base_en});
    reg_if.valid <= 1'b0;
  endtask

  // Offer one face after a random gap and wait for its beat.
  task automatic send_face(input face_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      face_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    face_if.valid          <= 1'b1;
    face_if.cell_vel_left  <= f.cvl;
    face_if.cell_vel_right <= f.cvr;
    face_if.full_vel_left  <= f.fvl;
    face_if.full_vel_right <= f.fvr;
    face_if.aux_left       <= f.axl;
    face_if.aux_right      <= f.axr;
    face_if.base_vel       <= f.base;
    face_if.ghost_vel      <= f.ghost;
    face_if.face_position  <= f.pos;
    do @(posedge clk_i); while (!face_if.ready);
  endtask

  // Pause until every predicted result has come back.
  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Mix of full-range, small, mid-range and extreme Q16.16 values.
  function automatic logic [VelW-1:0] random_vel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom;
    if (pick < 75) return 32'($urandom_range(32'h0006_0000)) - 32'h0003_0000;
    if (pick < 90) return 32'($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000;
    case ($urandom_range(4))
      0: return VelMax;
      1: return VelMin;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic face_t random_face();
    face_t f;
    f.cvl   = random_vel();
    f.cvr   = random_vel();
    f.fvl   = random_vel();
    f.fvr   = random_vel();
    f.axl   = random_vel();
    f.axr   = random_vel();
    f.base  = random_vel();
    f.ghost = random_vel();
    f.pos   = PosW'($urandom_range(3));
    // Some faces with nearly opposite states, to land near the zero threshold.
    if ($urandom_range(9) == 0) begin
      f.axr = -f.axl + 32'($urandom_range(32'h400)) - 32'h200;
      f.cvr = -f.cvl + 32'($urandom_range(32'h400)) - 32'h200;
    end
    return f;
  endfunction

  // Every velocity field set to one value.
  function automatic face_t uniform_face(input logic [VelW-1:0] v, input logic [PosW-1:0] pos);
    face_t f;
    f = '{v, v, v, v, v, v, v, v, pos};
    return f;
  endfunction

  // Given edge states, base and position for edge-value mode; the other fields are noise.
  function automatic face_t edge_face(input logic [VelW-1:0] l, input logic [VelW-1:0] r,
                                      input logic [VelW-1:0] base,
                                      input logic [PosW-1:0] pos);
    face_t f;
    f      = random_face();
    f.axl  = l;
    f.axr  = r;
    f.base = base;
    f.pos  = pos;
    return f;
  endfunction

  // Random register setting per phase; the first two pin the extremes.
  task automatic random_config(input int unsigned phase);
    logic [VelW-1:0] ch;
    logic [ThrW-1:0] thr;
    if (phase == 0) begin
      load_config(1'b0, VelMax, {ThrW{1'b1}}, BcWall, BcOutflow, 1'b1);
    end else if (phase == 1) begin
      load_config(1'b1, '0, '0, BcInflow, BcInflow, 1'b0);
    end else begin
      case ($urandom_range(3))
        0: ch = '0;
        1: ch = 32'($urandom_range(32'h0001_0000));
        2: ch = $urandom;
        default: ch = VelMax;
      endcase
      case ($urandom_range(3))
        0: thr = '0;
        1: thr = ThrW'($urandom_range(32'h400));
        2: thr = ThrW'($urandom);
        default: thr = {ThrW{1'b1}};
      endcase
      load_config(1'($urandom), ch, thr, bc_kind_e'($urandom_range(3)),
                  bc_kind_e'($urandom_range(3)), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    face_t f;
    rst_ni       = 1'b0;
    hold_req     = 1'b0;
    tx_idle_pct  = IdlePct;
    rx_idle_pct  = IdlePct;
    face_if.valid = 1'b0;
    {face_if.cell_vel_left, face_if.cell_vel_right, face_if.full_vel_left,
     face_if.full_vel_right, face_if.aux_left, face_if.aux_right,
     face_if.base_vel, face_if.ghost_vel} = '0;
    face_if.face_position = FaceInterior;
    reg_if.valid = 1'b0;
    reg_if.index = CfgExtrapMode;
    reg_if.data  = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: extreme fields on every face position.
    send_face(uniform_face(VelMax, FaceInterior));
    send_face(uniform_face(VelMin, FaceInterior));
    send_face(uniform_face('0, FaceSpare));
    send_face(uniform_face(VelMax, FaceLow));
    send_face(uniform_face(VelMin, FaceHigh));
    face_if.valid <= 1'b0;
    wait_drained();

    // Writes to missing registers, then slope mode with saturating Courant terms.
    write_reg(CfgSpareLo, $urandom);
    write_reg(CfgSpareHi, $urandom);
    load_config(1'b0, VelMax, {ThrW{1'b1}}, BcInflow, BcWall, 1'b1);
    f = random_face();
    f.fvl = VelMax;
    f.fvr = VelMin;
    f.pos = FaceInterior;
    send_face(f);
    f = random_face();
    f.pos = FaceLow;
    send_face(f);
    f = random_face();
    f.pos = FaceHigh;
    send_face(f);
    f = random_face();
    f.pos = FaceSpare;
    send_face(f);
    face_if.valid <= 1'b0;
    wait_drained();

    // Edge-value mode, outflow on both sides.
    load_config(1'b1, 32'h0000_8000, '0, BcOutflow, BcOutflow, 1'b0);
    send_face(edge_face(VelMax, VelMax, '0, FaceInterior));
    send_face(edge_face(32'h0003_0000, 32'hFFFB_0000, '0, FaceLow));
    send_face(edge_face(32'h0003_0000, 32'h0005_0000, '0, FaceLow));
    send_face(edge_face(32'h0004_0000, 32'hFFFE_0000, '0, FaceHigh));
    send_face(edge_face(32'hFFFC_0000, 32'h0002_0000, '0, FaceHigh));
    face_if.valid <= 1'b0;
    wait_drained();

    // Riemann cases: diverging, same signs, sum sign, zero sum; wall and inflow faces.
    load_config(1'b1, '0, '0, BcWall, BcInflow, 1'b0);
    send_face(edge_face(32'hFFFF_0000, 32'h0001_0000, '0, FaceInterior));
    send_face(edge_face(32'h0002_0000, 32'h0005_0000, '0, FaceInterior));
    send_face(edge_face(32'hFFFE_0000, 32'hFFFB_0000, '0, FaceInterior));
    send_face(edge_face(32'h0005_0000, 32'hFFFE_0000, '0, FaceInterior));
    send_face(edge_face(32'h0002_0000, 32'hFFFB_0000, '0, FaceInterior));
    send_face(edge_face(32'h0001_0000, 32'hFFFF_0000, '0, FaceInterior));
    send_face(edge_face(32'h0003_0000, 32'h0004_0000, '0, FaceLow));
    send_face(edge_face(32'h0003_0000, 32'h0004_0000, '0, FaceHigh));
    face_if.valid <= 1'b0;
    wait_drained();

    // Base velocity in the test, and a sum under the zero threshold.
    load_config(1'b1, '0, 31'h0001_0000, BcInterior, BcInterior, 1'b1);
    send_face(edge_face(32'h0003_0000, 32'h0004_0000, 32'hFFF6_0000, FaceInterior));
    send_face(edge_face(32'h0000_8000, 32'h0000_0000, '0, FaceInterior));
    send_face(edge_face(32'h0005_0000, 32'h0007_0000, 32'h0002_0000, FaceInterior));
    face_if.valid <= 1'b0;
    wait_drained();

    // Random phases: one with no idling, one with a long hold on the result side.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      random_config(phase);
      tx_idle_pct = (phase == 3) ? 0 : IdlePct;
      rx_idle_pct <= (phase == 3) ? 0 : IdlePct;
      hold_req <= (phase == 5);
      for (int unsigned n = 0; n < PhaseFaces; n++) begin
        send_face(random_face());
      end
      face_if.valid <= 1'b0;
      hold_req <= 1'b0;
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (4 * PipeDepth) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("upwind_face_velocity verification clean");
    end else begin
      $display("upwind_face_velocity verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ufv_pkg.sv
rtl/ufv_if.sv
rtl/ufv_riemann.sv
rtl/upwind_face_velocity.sv
tb/sv/ufv_velocity_checker.sv
tb/sv/tb_upwind_face_velocity.sv
